>>> hdl/rial_pkg.sv
// shared types and codes for the integer alu with hi/lo
package rial_pkg;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic [1:0] EXC_NONE  = 2'd0;
  localparam logic [1:0] EXC_OVF   = 2'd1;
  localparam logic [1:0] EXC_DIV0  = 2'd2;
  localparam logic [1:0] EXC_UNSUP = 2'd3;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  shift_amount;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [15:0] immediate;
  } rial_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        dest_write;
    logic [1:0]  exception;
  } rial_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item and its combinational result
    logic mul_step;  // sum partial products into hi/lo
    logic div_step;  // one quotient bit
    logic div_fix;   // sign fix and hi/lo write
  } rial_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
  } rial_sts_t;

endpackage

>>> hdl/rial_ctrl.sv
// sequencer for the alu: simple ops, multiply and iterative divide
module rial_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rial_pkg::rial_sts_t sts,
  output rial_pkg::rial_cmd_t cmd
);
  import rial_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_MUL, S_DIV, S_FIX} state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       acc;

  // a new item may enter when idle and the output register is free or being drained
  assign in_stall  = !(state_r == S_IDLE && (!out_valid_r || !out_stall));
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_mul) begin
          state_nxt = S_MUL;
        end else if (sts.is_div) begin
          cnt_nxt   = 6'(DIV_STEPS);
          state_nxt = S_DIV;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_step  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.div_fix   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_div_ends_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == 6'd1) |=> (state_r == S_FIX))
    else $error("divide did not finish");
  a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == S_DECODE)) else $error("no decode after transfer");
`endif
endmodule

>>> hdl/rial_dp.sv
// alu datapath: operand registers, hi/lo, multiplier and restoring divider
module rial_dp (
  input  logic                clk,
  input  rial_pkg::rial_in_t  in_data,
  input  rial_pkg::rial_cmd_t cmd,
  output rial_pkg::rial_sts_t sts,
  output rial_pkg::rial_out_t out_data,
  input  logic                rst_n
);
  import rial_pkg::*;

  rial_in_t    it_r;
  logic [31:0] hi_r, lo_r;
  rial_out_t   out_r;
  logic [31:0] q_r, rem_r, dvs_r;
  logic        neg_q_r, neg_r_r;
  logic [31:0] pll_r, plh_r, phl_r, phh_r;

  logic [31:0] a, b, se, sum, diff, sumi, ssh;
  logic [4:0]  sh;
  logic        is_r;
  logic [32:0] trial;
  logic [63:0] prod;
  logic [31:0] ma, mb;

  always_comb begin
    a    = in_data.rs_value;
    b    = in_data.rt_value;
    se   = {{16{in_data.immediate[15]}}, in_data.immediate};
    sum  = a + b;
    diff = a - b;
    sumi = a + se;
    is_r = (in_data.opcode == OP_RTYPE);
    sh   = (in_data.funct[2]) ? a[4:0] : in_data.shift_amount;
    ssh  = 32'($signed(b) >>> sh);
    ma   = a[31] ? 32'(-a) : a;
    mb   = b[31] ? 32'(-b) : b;
  end

  // combinational result, registered on load
  rial_out_t   fast;
  always_comb begin
    fast = '{result: '0, dest_write: 1'b1, exception: EXC_NONE};
    if (is_r) begin
      case (in_data.funct)
        FN_SLL, FN_SLLV: fast.result = b << sh;
        FN_SRL, FN_SRLV: fast.result = b >> sh;
        FN_SRA, FN_SRAV: fast.result = ssh;
        FN_MFHI:         fast.result = hi_r;
        FN_MFLO:         fast.result = lo_r;
        FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU: fast.dest_write = 1'b0;
        FN_DIV, FN_DIVU: begin
          fast.dest_write = 1'b0;
          if (b == '0) fast.exception = EXC_DIV0;
        end
        FN_ADD: begin
          if ((a[31] ^ sum[31]) & (b[31] ^ sum[31])) fast.exception = EXC_OVF;
          else fast.result = sum;
        end
        FN_ADDU: fast.result = sum;
        FN_SUB: begin
          if ((a[31] ^ b[31]) & (a[31] ^ diff[31])) fast.exception = EXC_OVF;
          else fast.result = diff;
        end
        FN_SUBU: fast.result = diff;
        FN_AND:  fast.result = a & b;
        FN_OR:   fast.result = a | b;
        FN_XOR:  fast.result = a ^ b;
        FN_NOR:  fast.result = ~(a | b);
        FN_SLT:  fast.result = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: fast.result = {31'd0, a < b};
        default: fast.exception = EXC_UNSUP;
      endcase
    end else begin
      case (in_data.opcode)
        OP_ADDI: begin
          if ((a[31] ^ sumi[31]) & (se[31] ^ sumi[31])) fast.exception = EXC_OVF;
          else fast.result = sumi;
        end
        OP_ADDIU: fast.result = sumi;
        OP_SLTI:  fast.result = {31'd0, $signed(a) < $signed(se)};
        OP_SLTIU: fast.result = {31'd0, a < se};
        OP_ANDI:  fast.result = a & {16'd0, in_data.immediate};
        OP_ORI:   fast.result = a | {16'd0, in_data.immediate};
        OP_XORI:  fast.result = a ^ {16'd0, in_data.immediate};
        OP_LUI:   fast.result = {in_data.immediate, 16'd0};
        default:  fast.exception = EXC_UNSUP;
      endcase
    end
    if (fast.exception != EXC_NONE) fast.dest_write = 1'b0;
  end

  // multiply operands after sign handling; unsigned 32x32 in four 16x16 products
  logic        mneg, msgn;
  logic [31:0] mua, mub;
  logic        mneg_r;
  assign msgn = (it_r.funct == FN_MULT);
  assign mua  = (msgn && it_r.rs_value[31]) ? 32'(-it_r.rs_value) : it_r.rs_value;
  assign mub  = (msgn && it_r.rt_value[31]) ? 32'(-it_r.rt_value) : it_r.rt_value;
  assign mneg = msgn && (it_r.rs_value[31] ^ it_r.rt_value[31]);

  always_comb begin
    prod = {32'd0, pll_r} + {16'd0, phl_r, 16'd0} + {16'd0, plh_r, 16'd0}
         + {phh_r, 32'd0};
    if (mneg_r) prod = 64'(-prod);
  end

  assign trial = {rem_r, q_r[31]} - {1'b0, dvs_r};

  assign sts.is_mul = (it_r.opcode == OP_RTYPE) &&
                      (it_r.funct == FN_MULT || it_r.funct == FN_MULTU);
  assign sts.is_div = (it_r.opcode == OP_RTYPE) && (it_r.rt_value != '0) &&
                      (it_r.funct == FN_DIV || it_r.funct == FN_DIVU);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r  <= '0;
      lo_r  <= '0;
      it_r  <= '0;
      out_r <= '0;
    end else begin
      if (cmd.load) begin
        it_r  <= in_data;
        out_r <= fast;
        if (is_r && in_data.funct == FN_MTHI) hi_r <= a;
        if (is_r && in_data.funct == FN_MTLO) lo_r <= a;
        // divider start: magnitudes for signed, raw for unsigned
        neg_q_r <= (in_data.funct == FN_DIV) && (a[31] ^ b[31]);
        neg_r_r <= (in_data.funct == FN_DIV) && a[31];
        q_r     <= (in_data.funct == FN_DIV) ? ma : a;
        dvs_r   <= (in_data.funct == FN_DIV) ? mb : b;
        rem_r   <= '0;
      end
      if (sts.is_mul && !cmd.mul_step) begin
        pll_r  <= {16'd0, mua[15:0]} * {16'd0, mub[15:0]};
        plh_r  <= {16'd0, mua[15:0]} * {16'd0, mub[31:16]};
        phl_r  <= {16'd0, mua[31:16]} * {16'd0, mub[15:0]};
        phh_r  <= {16'd0, mua[31:16]} * {16'd0, mub[31:16]};
        mneg_r <= mneg;
      end
      if (cmd.mul_step) begin
        hi_r <= prod[63:32];
        lo_r <= prod[31:0];
      end
      if (cmd.div_step) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], q_r[31]};
          q_r   <= {q_r[30:0], 1'b0};
        end
      end
      if (cmd.div_fix) begin
        lo_r <= neg_q_r ? 32'(-q_r) : q_r;
        hi_r <= neg_r_r ? 32'(-rem_r) : rem_r;
      end
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_fix_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_fix |-> $past(cmd.div_step)) else $error("fix without divide");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |=> $stable(out_r)) else $error("result changed while held");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("overlapping commands");
`endif
endmodule

>>> hdl/risc_integer_alu_hilo.sv
// Integer execute unit for 32-bit MIPS instructions with HI/LO registers.
// One item enters at a time and gives one result. Logic, shift, add/sub, slt
// and move operations deliver the result registered at transfer; mult/multu
// form four 16x16 partial products, then a sum; div/divu run the restoring
// divider that produces one quotient bit per cycle, then a sign fix. A division by
// zero returns at once with no change to HI/LO. The next item is taken when the
// unit is idle and the output register is free or being drained.
module risc_integer_alu_hilo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rial_pkg::rial_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rial_pkg::rial_out_t out_data
);
  import rial_pkg::*;

  rial_cmd_t cmd;
  rial_sts_t sts;

  rial_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rial_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data),
    .rst_n    (rst_n)
  );
endmodule
